// ===== sv/mm4_pkg.sv =====
// shared constants and types for the 4x4 fixed-point matrix multiplier
// used by mm4_front, mm4_queue, mm4_back and matrix_multiply_4x4_core
package mm4_pkg;

  localparam int Dim        = 4;
  localparam int FracBits   = 16;
  localparam int WordW      = 32;
  localparam int RowIdxW    = $clog2(Dim);
  localparam int QueueDepth = 2;

  typedef logic signed [WordW-1:0] word_t;

  // one loaded row pair, tagged by the front end
  typedef struct packed {
    word_t [Dim-1:0]    a;
    word_t [Dim-1:0]    b;
    logic [RowIdxW-1:0] row;
    logic               last;
  } row_entry_t;

  typedef enum logic {
    BkLoad,
    BkCalc
  } back_state_e;

endpackage

// ===== sv/mm4_front.sv =====
// front end: accepts input rows, tracks the row count and tags each row
// depends on mm4_pkg
module mm4_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mm4_pkg::word_t [mm4_pkg::Dim-1:0] a_row_i,
  input  mm4_pkg::word_t [mm4_pkg::Dim-1:0] b_row_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output mm4_pkg::row_entry_t   q_entry_o
);

  logic [mm4_pkg::RowIdxW-1:0] rows_q, rows_d;
  logic                        last_row;

  assign last_row   = (rows_q == mm4_pkg::RowIdxW'(mm4_pkg::Dim - 1));
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_entry_o.a    = a_row_i;
    q_entry_o.b    = b_row_i;
    q_entry_o.row  = rows_q;
    q_entry_o.last = last_row;
    rows_d         = rows_q;
    if (q_push_o) begin
      rows_d = last_row ? '0 : rows_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else begin
      rows_q <= rows_d;
    end
  end

endmodule

// ===== sv/mm4_queue.sv =====
// short fifo of tagged rows between front end and back end
// depends on mm4_pkg
module mm4_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mm4_pkg::row_entry_t entry_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output mm4_pkg::row_entry_t entry_o
);

  localparam int PtrW = $clog2(mm4_pkg::QueueDepth);
  localparam int CntW = $clog2(mm4_pkg::QueueDepth + 1);

  mm4_pkg::row_entry_t mem_q [mm4_pkg::QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntW'(mm4_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(mm4_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(mm4_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== sv/mm4_back.sv =====
// back end: row stores per lane, element sequencer, multiply and sum pipeline
// depends on mm4_pkg
module mm4_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  mm4_pkg::row_entry_t q_entry_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mm4_pkg::word_t [mm4_pkg::Dim-1:0] out_row_o,
  output logic                out_last_o
);

  localparam int ProdW = 2 * mm4_pkg::WordW;
  localparam int SumW  = ProdW + $clog2(mm4_pkg::Dim);
  localparam int ShW   = SumW - mm4_pkg::FracBits;
  localparam int RW    = mm4_pkg::RowIdxW;

  // floor shift by the fraction bits, then clamp to the word range
  function automatic mm4_pkg::word_t sat_word(input logic signed [SumW-1:0] s);
    logic [ShW-1:0] sh;
    sh = s[SumW-1:mm4_pkg::FracBits];
    if (sh[ShW-1:mm4_pkg::WordW-1] == {(ShW - mm4_pkg::WordW + 1){sh[ShW-1]}}) begin
      return sh[mm4_pkg::WordW-1:0];
    end else if (sh[ShW-1]) begin
      return {1'b1, {(mm4_pkg::WordW - 1){1'b0}}};
    end else begin
      return {1'b0, {(mm4_pkg::WordW - 1){1'b1}}};
    end
  endfunction

  mm4_pkg::back_state_e state_q, state_d;

  // lane k holds column k of the left matrix and row k of the right matrix
  mm4_pkg::word_t a_store_q [mm4_pkg::Dim][mm4_pkg::Dim];
  mm4_pkg::word_t b_store_q [mm4_pkg::Dim][mm4_pkg::Dim];

  logic                    issuing_q;
  logic [RW-1:0]           iss_j_q;
  logic [RW-1:0]           row_i_q;
  logic                    s1_v_q, s2_v_q;
  logic [RW-1:0]           s1_j_q, s2_j_q;
  logic signed [ProdW-1:0] prod_q [mm4_pkg::Dim];
  logic signed [SumW-1:0]  sum_q, sum_d;
  mm4_pkg::word_t [mm4_pkg::Dim-1:0] res_q;
  logic                    out_valid_q, out_last_q;
  logic                    start, out_done;

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_row_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mm4_pkg::BkLoad;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    start    = 1'b0;
    out_done = 1'b0;
    case (state_q)
      mm4_pkg::BkLoad: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_entry_i.last) begin
            state_d = mm4_pkg::BkCalc;
          end
        end
      end
      mm4_pkg::BkCalc: begin
        start    = !issuing_q && !out_valid_q && !s1_v_q && !s2_v_q;
        out_done = out_valid_q && !out_stall_i;
        if (out_done && out_last_q) begin
          state_d = mm4_pkg::BkLoad;
        end
      end
      default: begin
        state_d = mm4_pkg::BkLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q   <= 1'b0;
      iss_j_q     <= '0;
      row_i_q     <= '0;
      s1_v_q      <= 1'b0;
      s1_j_q      <= '0;
      s2_v_q      <= 1'b0;
      s2_j_q      <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (q_pop_o && q_entry_i.last) begin
        row_i_q <= '0;
      end
      if (start) begin
        issuing_q <= 1'b1;
        iss_j_q   <= '0;
      end else if (issuing_q) begin
        iss_j_q <= iss_j_q + 1'b1;
        if (iss_j_q == RW'(mm4_pkg::Dim - 1)) begin
          issuing_q <= 1'b0;
        end
      end
      s1_v_q <= issuing_q;
      s1_j_q <= iss_j_q;
      s2_v_q <= s1_v_q;
      s2_j_q <= s1_j_q;
      if (s2_v_q && (s2_j_q == RW'(mm4_pkg::Dim - 1))) begin
        out_valid_q <= 1'b1;
        out_last_q  <= (row_i_q == RW'(mm4_pkg::Dim - 1));
      end else if (out_done) begin
        out_valid_q <= 1'b0;
        if (!out_last_q) begin
          row_i_q <= row_i_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < mm4_pkg::Dim; k++) begin
      sum_d = sum_d + {{(SumW - ProdW){prod_q[k][ProdW-1]}}, prod_q[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < mm4_pkg::Dim; k++) begin
      if (q_pop_o) begin
        a_store_q[k][q_entry_i.row] <= q_entry_i.a[k];
        if (q_entry_i.row == RW'(k)) begin
          for (int j = 0; j < mm4_pkg::Dim; j++) begin
            b_store_q[k][j] <= q_entry_i.b[j];
          end
        end
      end
      prod_q[k] <= $signed(a_store_q[k][row_i_q]) * $signed(b_store_q[k][iss_j_q]);
    end
    sum_q <= sum_d;
    if (s2_v_q) begin
      res_q[s2_j_q] <= sat_word(sum_q);
    end
  end

endmodule

// ===== sv/matrix_multiply_4x4_core.sv =====
// top level of the 4x4 signed q16.16 matrix multiplier, c = a x b
// depends on mm4_pkg, mm4_front, mm4_queue, mm4_back
// - input channel (in_valid_i / in_stall_o): each transfer brings row r of a
//   and row r of b; rows go in order 0..3, the fourth closes a matrix pair
// - output channel (out_valid_o / out_stall_i): after the fourth input row the
//   block gives four rows of c, row 0 first, row_last_o high on row 3
// - each element is the exact sum of four 64-bit products, floor-shifted by 16
//   and saturated to the signed 32-bit range
// - the front end tags rows and pushes them into a two-entry queue; the back
//   end loads rows into its lane stores and then runs the product pass
// - in the back end each result row runs as a start step, the issue of the
//   four elements, the product register, the sum register and the output
//   register; a result row is started only when the previous one has left
//   these registers
// - while the back end computes, up to two rows of the next pair wait in the
//   queue; after that in_stall_o rises
// - when the receiver stalls, the finished row holds in the output register
//   and the next row is not started until it is transferred
// - reset clears the row count, the queue and all valid flags; row stores hold
//   nothing until the first four rows are loaded
module matrix_multiply_4x4_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] a_col0_i,
  input  logic signed [31:0] a_col1_i,
  input  logic signed [31:0] a_col2_i,
  input  logic signed [31:0] a_col3_i,
  input  logic signed [31:0] b_col0_i,
  input  logic signed [31:0] b_col1_i,
  input  logic signed [31:0] b_col2_i,
  input  logic signed [31:0] b_col3_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] c_col0_o,
  output logic signed [31:0] c_col1_o,
  output logic signed [31:0] c_col2_o,
  output logic signed [31:0] c_col3_o,
  output logic        row_last_o
);

  mm4_pkg::word_t [mm4_pkg::Dim-1:0] a_row, b_row, c_row;
  mm4_pkg::row_entry_t push_entry, pop_entry;
  logic                q_push, q_full, q_valid, q_pop;

  // pack the field ports into row vectors
  assign a_row = {a_col3_i, a_col2_i, a_col1_i, a_col0_i};
  assign b_row = {b_col3_i, b_col2_i, b_col1_i, b_col0_i};

  // front end: row count and tagging
  mm4_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .a_row_i    (a_row),
    .b_row_i    (b_row),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  // decoupling queue
  mm4_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (pop_entry)
  );

  // back end: stores, product pipeline and output register
  mm4_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_row_o   (c_row),
    .out_last_o  (row_last_o)
  );

  // unpack the result row
  assign c_col0_o = c_row[0];
  assign c_col1_o = c_row[1];
  assign c_col2_o = c_row[2];
  assign c_col3_o = c_row[3];

endmodule
